>>> hw/rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned PHASE_W    = 5;
  localparam int unsigned LIMIT_W    = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd250;

  // Phase at which the data bits of a byte end.
  localparam logic [PHASE_W-1:0] BODY_PHASE = PHASE_W'(2 * BYTE_BITS);

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [BYTE_BITS-1:0] write_byte;
    logic                 ack_after_read;
    logic                 sda_in;
  } item_t;

endpackage

>>> hw/rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine.
`timescale 1ns / 1ps
// The input channel carries one half-bit tick per item, with the sampled SDA
// level and, while the engine is idle, an optional command: start, stop, write
// byte, read byte with ACK or NACK, or wait for acknowledge.
// The output channel returns one result item per input item, in order: the
// SCL and SDA drive levels for that tick, busy and done flags, the last read
// byte and the acknowledge timeout flag.
// A result passes through the front queue and then the sequencer's output
// register before it appears.
// The engine takes one item per clock cycle when the receiver does not stall.
// The sequencer state is updated once per tick by combinational next-state
// logic, so that update sets the rate.
// When the receiver stalls, the output register holds its item, the sequencer
// waits, and the front queue absorbs up to QUEUE_DEPTH more items before
// raising in_stall.
// The acknowledge poll limit is written through cfg_wr_en and cfg_wr_data; the user
// writes it while the engine is idle, which the block itself does not enforce.
// A synchronous reset empties the queue and output register, sets the sequencer's
// line state to released on both lines and sets the poll limit to 250.
module i2c_master_bit_engine #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [i2cm_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     cmd,
  input  logic [i2cm_pkg::BYTE_BITS-1:0] write_byte,
  input  logic                           ack_after_read,
  input  logic                           sda_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           scl_level,
  output logic                           sda_pull_low,
  output logic                           busy_res,
  output logic                           done_res,
  output logic [i2cm_pkg::BYTE_BITS-1:0] read_byte,
  output logic                           no_ack
);

  logic            push;
  logic            pop;
  logic            full;
  logic            q_valid;
  i2cm_pkg::item_t front_item;
  i2cm_pkg::item_t q_item;

  assign in_stall = full;

  i2cm_front u_front (
    .in_valid       (in_valid),
    .cmd            (cmd),
    .write_byte     (write_byte),
    .ack_after_read (ack_after_read),
    .sda_in         (sda_in),
    .push           (push),
    .item           (front_item),
    .full           (full)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (q_item),
    .not_empty (q_valid),
    .full      (full)
  );

  i2cm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_level    (scl_level),
    .sda_pull_low (sda_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_byte    (read_byte),
    .no_ack       (no_ack)
  );

endmodule

>>> hw/rtl/i2cm_front.sv
// Front end: classifies each incoming item into a queued command item.
`timescale 1ns / 1ps

module i2cm_front (
  input  logic                           in_valid,
  input  logic [2:0]                     cmd,
  input  logic [i2cm_pkg::BYTE_BITS-1:0] write_byte,
  input  logic                           ack_after_read,
  input  logic                           sda_in,
  output logic                           push,
  output i2cm_pkg::item_t                item,
  input  logic                           full
);

  always_comb begin
    case (cmd)
      i2cm_pkg::CMD_START: item.cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::CMD_STOP:  item.cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::CMD_WRITE: item.cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::CMD_READ:  item.cmd = i2cm_pkg::CMD_READ;
      i2cm_pkg::CMD_WAIT:  item.cmd = i2cm_pkg::CMD_WAIT;
      default:             item.cmd = i2cm_pkg::CMD_TICK;
    endcase
    item.write_byte     = write_byte;
    item.ack_after_read = ack_after_read;
    item.sda_in         = sda_in;
  end

  assign push = in_valid && !full;

endmodule

>>> hw/rtl/i2cm_queue.sv
// Short register queue between the front end and the sequencer.
`timescale 1ns / 1ps

module i2cm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cm_pkg::item_t push_item,
  input  logic            pop,
  output i2cm_pkg::item_t head_item,
  output logic            not_empty,
  output logic            full
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  i2cm_pkg::item_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_item = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/i2cm_back.sv
// Back end: line sequencer that runs one tick per item and holds the result register.
`timescale 1ns / 1ps

module i2cm_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [i2cm_pkg::LIMIT_W-1:0]         cfg_wr_data,
  input  logic                                 q_valid,
  input  i2cm_pkg::item_t                      q_item,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 scl_level,
  output logic                                 sda_pull_low,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [i2cm_pkg::BYTE_BITS-1:0]       read_byte,
  output logic                                 no_ack
);

  localparam int unsigned BW = i2cm_pkg::BYTE_BITS;
  localparam int unsigned PW = i2cm_pkg::PHASE_W;

  logic [i2cm_pkg::LIMIT_W-1:0] ack_poll_limit;
  logic [PW-1:0]                phase;
  i2cm_pkg::cmd_t               active_command;
  logic [BW-1:0]                shift_reg;
  logic [i2cm_pkg::LIMIT_W-1:0] poll_count;
  logic                         ack_choice;
  logic                         scl_out;
  logic                         sda_low_out;
  logic                         ack_failed;
  logic [BW-1:0]                read_result;

  logic [PW-1:0]                phase_next;
  i2cm_pkg::cmd_t               active_command_next;
  logic [BW-1:0]                shift_reg_next;
  logic [i2cm_pkg::LIMIT_W-1:0] poll_count_next;
  logic                         ack_choice_next;
  logic                         scl_out_next;
  logic                         sda_low_out_next;
  logic                         ack_failed_next;
  logic [BW-1:0]                read_result_next;
  logic                         finish;
  logic                         hold;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    phase_next          = phase;
    active_command_next = active_command;
    shift_reg_next      = shift_reg;
    poll_count_next     = poll_count;
    ack_choice_next     = ack_choice;
    scl_out_next        = scl_out;
    sda_low_out_next    = sda_low_out;
    ack_failed_next     = ack_failed;
    read_result_next    = read_result;
    finish              = 1'b0;
    hold                = 1'b0;

    if (active_command == i2cm_pkg::CMD_TICK && q_item.cmd != i2cm_pkg::CMD_TICK) begin
      active_command_next = q_item.cmd;
      phase_next          = '0;
      poll_count_next     = '0;
      case (q_item.cmd)
        i2cm_pkg::CMD_WRITE: shift_reg_next = q_item.write_byte;
        i2cm_pkg::CMD_READ: begin
          shift_reg_next  = '0;
          ack_choice_next = q_item.ack_after_read;
        end
        i2cm_pkg::CMD_WAIT: ack_failed_next = 1'b0;
        default: ;
      endcase
    end

    case (active_command_next)
      i2cm_pkg::CMD_START: begin
        if (phase_next == PW'(0)) begin
          sda_low_out_next = 1'b0;
          scl_out_next     = 1'b1;
        end else if (phase_next == PW'(1)) begin
          sda_low_out_next = 1'b1;
        end else begin
          scl_out_next = 1'b0;
          finish       = 1'b1;
        end
      end
      i2cm_pkg::CMD_STOP: begin
        if (phase_next == PW'(0)) begin
          scl_out_next     = 1'b0;
          sda_low_out_next = 1'b1;
        end else if (phase_next == PW'(1)) begin
          scl_out_next = 1'b1;
        end else begin
          sda_low_out_next = 1'b0;
          finish           = 1'b1;
        end
      end
      i2cm_pkg::CMD_WRITE: begin
        if (phase_next < i2cm_pkg::BODY_PHASE) begin
          if (!phase_next[0]) begin
            scl_out_next     = 1'b0;
            sda_low_out_next = !shift_reg_next[BW-1];
          end else begin
            scl_out_next   = 1'b1;
            shift_reg_next = {shift_reg_next[BW-2:0], 1'b0};
          end
        end else begin
          scl_out_next = 1'b0;
          finish       = 1'b1;
        end
      end
      i2cm_pkg::CMD_READ: begin
        if (phase_next < i2cm_pkg::BODY_PHASE) begin
          if (!phase_next[0]) begin
            scl_out_next     = 1'b0;
            sda_low_out_next = 1'b0;
          end else begin
            scl_out_next   = 1'b1;
            shift_reg_next = {shift_reg_next[BW-2:0], q_item.sda_in};
          end
        end else if (phase_next == i2cm_pkg::BODY_PHASE) begin
          scl_out_next     = 1'b0;
          sda_low_out_next = ack_choice_next;
        end else if (phase_next == i2cm_pkg::BODY_PHASE + PW'(1)) begin
          scl_out_next = 1'b1;
        end else begin
          scl_out_next     = 1'b0;
          read_result_next = shift_reg_next;
          finish           = 1'b1;
        end
      end
      i2cm_pkg::CMD_WAIT: begin
        if (phase_next == PW'(0)) begin
          scl_out_next     = 1'b0;
          sda_low_out_next = 1'b0;
        end else if (phase_next == PW'(1)) begin
          scl_out_next = 1'b1;
        end else if (!q_item.sda_in) begin
          scl_out_next    = 1'b0;
          ack_failed_next = 1'b0;
          finish          = 1'b1;
        end else if (poll_count_next >= ack_poll_limit) begin
          ack_failed_next     = 1'b1;
          active_command_next = i2cm_pkg::CMD_STOP;
          phase_next          = '0;
          scl_out_next        = 1'b0;
          sda_low_out_next    = 1'b1;
        end else begin
          poll_count_next = poll_count_next + i2cm_pkg::LIMIT_W'(1);
          hold            = 1'b1;
        end
      end
      default: ;
    endcase

    if (finish) begin
      active_command_next = i2cm_pkg::CMD_TICK;
      phase_next          = '0;
    end else if (!hold && active_command_next != i2cm_pkg::CMD_TICK) begin
      phase_next = phase_next + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_poll_limit <= i2cm_pkg::LIMIT_RESET;
      phase          <= '0;
      active_command <= i2cm_pkg::CMD_TICK;
      shift_reg      <= '0;
      poll_count     <= '0;
      ack_choice     <= 1'b0;
      scl_out        <= 1'b1;
      sda_low_out    <= 1'b0;
      ack_failed     <= 1'b0;
      read_result    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ack_poll_limit <= cfg_wr_data;
      end
      if (pop) begin
        phase          <= phase_next;
        active_command <= active_command_next;
        shift_reg      <= shift_reg_next;
        poll_count     <= poll_count_next;
        ack_choice     <= ack_choice_next;
        scl_out        <= scl_out_next;
        sda_low_out    <= sda_low_out_next;
        ack_failed     <= ack_failed_next;
        read_result    <= read_result_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scl_level    <= scl_out_next;
      sda_pull_low <= sda_low_out_next;
      busy_res     <= (active_command_next != i2cm_pkg::CMD_TICK);
      done_res     <= finish;
      read_byte    <= read_result_next;
      no_ack       <= ack_failed_next;
    end
  end

endmodule

>>> hw/rtl/i2cm_checker.sv
// Port-level checker for the I2C master bit engine and its bind.
`timescale 1ns / 1ps

module i2cm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           scl_level,
  input logic                           sda_pull_low,
  input logic                           busy_res,
  input logic                           done_res,
  input logic [i2cm_pkg::BYTE_BITS-1:0] read_byte,
  input logic                           no_ack
);

  // The output side is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("result item present right after reset");

  // A stalled result item keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_pull_low)
      && $stable(busy_res) && $stable(done_res) && $stable(read_byte) && $stable(no_ack))
    else $error("stalled result item changed");

  // A finished command leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done and busy on the same item");

  // Only a stop finishes with SCL high, and it has released SDA.
  a_stop_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && scl_level |-> !sda_pull_low)
    else $error("command finished with SCL high and SDA pulled low");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .scl_level    (scl_level),
  .sda_pull_low (sda_pull_low),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .read_byte    (read_byte),
  .no_ack       (no_ack)
);
